>>> hdl/segregated_block_pool_allocator_unit_assert.svh
// Assertion macros for the segregated block pool allocator.
// No dependencies; included by the top level for its checks.
`ifndef SEGREGATED_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define SEGREGATED_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define SBPA_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication, checked out of reset.
`define SBPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/sbpa_pkg.sv
// Shared types, codes and block layout function for the block pool allocator.
// No dependencies.
package sbpa_pkg;

    // Default pool geometry
    localparam int SMALL_BYTES_DEF = 16;
    localparam int SMALL_COUNT_DEF = 8;
    localparam int MID_BYTES_DEF   = 32;
    localparam int MID_COUNT_DEF   = 8;
    localparam int LARGE_BYTES_DEF = 64;
    localparam int LARGE_COUNT_DEF = 4;

    localparam int HEADER_BYTES = 8;
    localparam int NUM_POOLS    = 3;

    typedef logic [1:0] t_pool;
    typedef logic [1:0] t_status;

    localparam t_pool POOL_SMALL = 2'd0;
    localparam t_pool POOL_MID   = 2'd1;
    localparam t_pool POOL_LARGE = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EXHAUSTED = 2'd1;
    localparam t_status ST_TOO_LARGE = 2'd2;
    localparam t_status ST_BAD_FREE  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Register byte address
    localparam logic [1:0] REG_AREA_BASE = 2'd0;

    // Header offset of block b from the region base (elaboration-time use)
    function automatic logic [31:0] block_start(input int b, input int sb, input int sc,
                                                input int mb, input int mc, input int lb);
        int off;
        begin
            if (b < sc) begin
                off = b * sb;
            end else if (b < sc + mc) begin
                off = sc * sb + (b - sc) * mb;
            end else begin
                off = sc * sb + mc * mb + (b - sc - mc) * lb;
            end
            return 32'(off);
        end
    endfunction

endpackage

>>> hdl/sbpa_free_map.sv
// Maps a header offset back to a block index and pool for a free transfer.
// Depends on sbpa_pkg for the block layout function and pool codes.
module sbpa_free_map #(
    parameter int SMALL_BYTES = sbpa_pkg::SMALL_BYTES_DEF,
    parameter int SMALL_COUNT = sbpa_pkg::SMALL_COUNT_DEF,
    parameter int MID_BYTES   = sbpa_pkg::MID_BYTES_DEF,
    parameter int MID_COUNT   = sbpa_pkg::MID_COUNT_DEF,
    parameter int LARGE_BYTES = sbpa_pkg::LARGE_BYTES_DEF,
    parameter int LARGE_COUNT = sbpa_pkg::LARGE_COUNT_DEF,
    parameter int TOTAL       = SMALL_COUNT + MID_COUNT + LARGE_COUNT,
    parameter int IDX_W       = $clog2(TOTAL + 1)
) (
    input  logic [31:0]         i_off,
    output logic                o_hit,
    output logic [IDX_W-1:0]    o_blk,
    output sbpa_pkg::t_pool     o_pool
);
    import sbpa_pkg::*;

    logic [31:0] c_start [TOTAL];
    logic [TOTAL-1:0] w_match;

    // Constant header offset of every block
    for (genvar g = 0; g < TOTAL; g++) begin : g_start
        assign c_start[g] = block_start(g, SMALL_BYTES, SMALL_COUNT,
                                        MID_BYTES, MID_COUNT, LARGE_BYTES);
        assign w_match[g] = (i_off == c_start[g]);
    end

    // Starts are distinct, so at most one block matches
    always_comb begin
        o_blk = '0;
        for (int b = 0; b < TOTAL; b++) begin
            if (w_match[b]) begin
                o_blk = o_blk | IDX_W'(b);
            end
        end
    end

    assign o_hit = |w_match;

    always_comb begin
        if (o_blk < IDX_W'(SMALL_COUNT)) begin
            o_pool = POOL_SMALL;
        end else if (o_blk < IDX_W'(SMALL_COUNT + MID_COUNT)) begin
            o_pool = POOL_MID;
        end else begin
            o_pool = POOL_LARGE;
        end
    end

endmodule

>>> hdl/segregated_block_pool_allocator_unit.sv
// Segregated block pool allocator: three fixed-size pools with LIFO free lists.
// Result strobe o_done comes from the result register, behind the input register.
// Throughput: one command per cycle; busy is never raised, free lists live in flip-flops.
// Reset (synchronous, i_rst_n low): lists rebuilt in ascending order, area_base to 0.
// Results cannot be stalled; each o_done pulse lasts one cycle.
// Depends on sbpa_pkg, sbpa_free_map and the assertion macro header.
`include "segregated_block_pool_allocator_unit_assert.svh"

module segregated_block_pool_allocator_unit #(
    parameter int SMALL_BYTES = sbpa_pkg::SMALL_BYTES_DEF,
    parameter int SMALL_COUNT = sbpa_pkg::SMALL_COUNT_DEF,
    parameter int MID_BYTES   = sbpa_pkg::MID_BYTES_DEF,
    parameter int MID_COUNT   = sbpa_pkg::MID_COUNT_DEF,
    parameter int LARGE_BYTES = sbpa_pkg::LARGE_BYTES_DEF,
    parameter int LARGE_COUNT = sbpa_pkg::LARGE_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // command channel
    input  logic                start,
    output logic                busy,
    input  logic                i_opcode,
    input  logic [15:0]         i_request_size,
    input  logic [31:0]         i_block_address,
    // result channel
    output logic                o_done,
    output logic [31:0]         o_granted_address,
    output sbpa_pkg::t_pool     o_pool_used,
    output sbpa_pkg::t_status   o_status
);
    import sbpa_pkg::*;

    localparam int TOTAL     = SMALL_COUNT + MID_COUNT + LARGE_COUNT;
    localparam int IDX_W     = $clog2(TOTAL + 1);
    localparam int AW        = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int MID_FIRST = SMALL_COUNT;
    localparam int LRG_FIRST = SMALL_COUNT + MID_COUNT;
    localparam logic [IDX_W-1:0] NULL_BLK = IDX_W'(TOTAL);

    // Configuration register
    logic [31:0] r_base;
    logic        w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr == REG_AREA_BASE);
    assign prdata   = (paddr == REG_AREA_BASE) ? r_base : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 32'd0;
        end else if (w_cfg_we) begin
            r_base <= pwdata;
        end
    end

    // Input register
    logic        r_in_valid;
    logic        r_opcode;
    logic [15:0] r_req;
    logic [31:0] r_addr;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_opcode <= i_opcode;
            r_req    <= i_request_size;
            r_addr   <= i_block_address;
        end
    end

    // Free list state
    logic [IDX_W-1:0] r_head [NUM_POOLS];
    logic [IDX_W-1:0] r_next [TOTAL];

    // Constant header offsets, read at the popped head
    logic [31:0] c_start [TOTAL];
    for (genvar g = 0; g < TOTAL; g++) begin : g_start
        assign c_start[g] = block_start(g, SMALL_BYTES, SMALL_COUNT,
                                        MID_BYTES, MID_COUNT, LARGE_BYTES);
    end

    // Size class choice: first pool whose usable bytes fit
    logic  w_fit;
    t_pool w_sel;

    always_comb begin
        w_fit = 1'b1;
        if (r_req <= 16'(SMALL_BYTES - HEADER_BYTES)) begin
            w_sel = POOL_SMALL;
        end else if (r_req <= 16'(MID_BYTES - HEADER_BYTES)) begin
            w_sel = POOL_MID;
        end else if (r_req <= 16'(LARGE_BYTES - HEADER_BYTES)) begin
            w_sel = POOL_LARGE;
        end else begin
            w_sel = POOL_SMALL;
            w_fit = 1'b0;
        end
    end

    logic [IDX_W-1:0] w_pop;
    logic [AW-1:0]    w_pop_a;

    assign w_pop   = r_head[w_sel];
    assign w_pop_a = w_pop[AW-1:0];

    // Free address decode
    logic [31:0]      w_off;
    logic             w_fm_hit;
    logic [IDX_W-1:0] w_fm_blk;
    t_pool            w_fm_pool;

    assign w_off = r_addr - 32'(HEADER_BYTES) - r_base;

    sbpa_free_map #(
        .SMALL_BYTES (SMALL_BYTES),
        .SMALL_COUNT (SMALL_COUNT),
        .MID_BYTES   (MID_BYTES),
        .MID_COUNT   (MID_COUNT),
        .LARGE_BYTES (LARGE_BYTES),
        .LARGE_COUNT (LARGE_COUNT),
        .TOTAL       (TOTAL),
        .IDX_W       (IDX_W)
    ) u_free_map (
        .i_off  (w_off),
        .o_hit  (w_fm_hit),
        .o_blk  (w_fm_blk),
        .o_pool (w_fm_pool)
    );

    // Command evaluation: one head write and one link write at most
    logic             n_done;
    logic [31:0]      n_granted;
    t_pool            n_pool;
    t_status          n_status;
    logic             w_head_we;
    t_pool            w_head_idx;
    logic [IDX_W-1:0] w_head_data;
    logic             w_next_we;
    logic [AW-1:0]    w_next_idx;
    logic [IDX_W-1:0] w_next_data;

    always_comb begin
        n_done      = r_in_valid;
        n_granted   = 32'd0;
        n_pool      = POOL_SMALL;
        n_status    = ST_OK;
        w_head_we   = 1'b0;
        w_head_idx  = w_sel;
        w_head_data = r_next[w_pop_a];
        w_next_we   = 1'b0;
        w_next_idx  = w_pop_a;
        w_next_data = NULL_BLK;
        if (r_in_valid) begin
            if (r_opcode == OP_ALLOC) begin
                if (!w_fit) begin
                    n_status = ST_TOO_LARGE;
                end else begin
                    n_pool = w_sel;
                    if (w_pop == NULL_BLK) begin
                        n_status = ST_EXHAUSTED;
                    end else begin
                        n_granted = r_base + c_start[w_pop_a] + 32'(HEADER_BYTES);
                        w_head_we = 1'b1;
                        w_next_we = 1'b1;
                    end
                end
            end else begin
                if (w_fm_hit) begin
                    n_pool      = w_fm_pool;
                    w_head_we   = 1'b1;
                    w_head_idx  = w_fm_pool;
                    w_head_data = w_fm_blk;
                    w_next_we   = 1'b1;
                    w_next_idx  = w_fm_blk[AW-1:0];
                    w_next_data = r_head[w_fm_pool];
                end else begin
                    n_status = ST_BAD_FREE;
                end
            end
        end
    end

    // List heads, reset to the first block of each pool
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head[POOL_SMALL] <= IDX_W'(0);
            r_head[POOL_MID]   <= IDX_W'(MID_FIRST);
            r_head[POOL_LARGE] <= IDX_W'(LRG_FIRST);
        end else if (w_head_we) begin
            r_head[w_head_idx] <= w_head_data;
        end
    end

    // Links, reset to ascending order with null at each pool's end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < TOTAL; b++) begin
                if (b == MID_FIRST - 1 || b == LRG_FIRST - 1 || b == TOTAL - 1) begin
                    r_next[b] <= NULL_BLK;
                end else begin
                    r_next[b] <= IDX_W'(b + 1);
                end
            end
        end else if (w_next_we) begin
            r_next[w_next_idx] <= w_next_data;
        end
    end

    // Result register
    logic        r_done;
    logic [31:0] r_granted;
    t_pool       r_pool;
    t_status     r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_granted <= n_granted;
        r_pool    <= n_pool;
        r_status  <= n_status;
    end

    assign o_done            = r_done;
    assign o_granted_address = r_granted;
    assign o_pool_used       = r_pool;
    assign o_status          = r_status;

    // Terms for the checks below
    logic w_in_xfer;
    logic w_fail;
    logic w_addr_zero;
    logic w_small_ok;
    logic w_mid_ok;
    logic w_large_ok;

    assign w_in_xfer   = start && !busy;
    assign w_fail      = o_done && (o_status != ST_OK);
    assign w_addr_zero = (o_granted_address == 32'd0);
    assign w_small_ok  = (r_head[POOL_SMALL] == NULL_BLK)
                      || (r_head[POOL_SMALL] < IDX_W'(MID_FIRST));
    assign w_mid_ok    = (r_head[POOL_MID] == NULL_BLK)
                      || ((r_head[POOL_MID] >= IDX_W'(MID_FIRST))
                          && (r_head[POOL_MID] < IDX_W'(LRG_FIRST)));
    assign w_large_ok  = (r_head[POOL_LARGE] == NULL_BLK)
                      || (r_head[POOL_LARGE] >= IDX_W'(LRG_FIRST));

    // Checks
    `SBPA_ASSERT_IMPLY(a_done_has_cmd, i_clk, i_rst_n, o_done, $past(w_in_xfer, 2), "stray result")
    `SBPA_ASSERT_IMPLY(a_fail_no_addr, i_clk, i_rst_n, w_fail, w_addr_zero, "address on failure")
    `SBPA_ASSERT_ALWAYS(a_small_head, i_clk, i_rst_n, w_small_ok, "small head out of pool")
    `SBPA_ASSERT_ALWAYS(a_mid_head, i_clk, i_rst_n, w_mid_ok, "mid head out of pool")
    `SBPA_ASSERT_ALWAYS(a_large_head, i_clk, i_rst_n, w_large_ok, "large head out of pool")

endmodule

>>> verif/tb_segregated_block_pool_allocator_unit.sv
// Self-checking testbench for the segregated block pool allocator unit.
// Depends on sbpa_pkg and the RTL top level; drives commands and the APB port,
// tracks the three free lists itself and checks every result strobe.
module tb_segregated_block_pool_allocator_unit;
    import sbpa_pkg::*;

    localparam int BLOCKS     = SMALL_COUNT_DEF + MID_COUNT_DEF + LARGE_COUNT_DEF;
    localparam int BLK_NONE   = BLOCKS;
    localparam int REGION     = SMALL_COUNT_DEF * SMALL_BYTES_DEF + MID_COUNT_DEF * MID_BYTES_DEF
                                + LARGE_COUNT_DEF * LARGE_BYTES_DEF;
    localparam int DIR_ROWS   = 24;
    localparam int RAND_PHASE = 150;

    typedef struct packed {
        logic [31:0] addr;
        t_pool       pool;
        t_status     status;
    } t_pool_reply;

    typedef struct packed {
        logic        op;
        logic [15:0] size;
        logic [31:0] addr;
        logic        typed;
        t_pool_reply reply;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        i_opcode;
    logic [15:0] i_request_size;
    logic [31:0] i_block_address;
    logic        o_done;
    logic [31:0] o_granted_address;
    t_pool       o_pool_used;
    t_status     o_status;

    // Typed-in expectation travelling with the current command
    logic        typed_on;
    t_pool_reply typed_reply;

    // Shadow of the allocator state
    logic [31:0] area_base_q;
    logic [4:0]  head_q [NUM_POOLS];
    logic [4:0]  link_q [BLOCKS];

    t_pool_reply replies_due [$];
    logic [31:0] live_addrs [$];
    int unsigned n_bad;
    bit          gaps_on;
    t_stim_row   dir_rows [DIR_ROWS];

    segregated_block_pool_allocator_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_request_size    (i_request_size),
        .i_block_address   (i_block_address),
        .o_done            (o_done),
        .o_granted_address (o_granted_address),
        .o_pool_used       (o_pool_used),
        .o_status          (o_status)
    );

    always #4 i_clk = ~i_clk;

    // Pool geometry
    function automatic logic [31:0] pbytes(input int p);
        return (p == 0) ? SMALL_BYTES_DEF : (p == 1) ? MID_BYTES_DEF : LARGE_BYTES_DEF;
    endfunction

    function automatic logic [31:0] pcount(input int p);
        return (p == 0) ? SMALL_COUNT_DEF : (p == 1) ? MID_COUNT_DEF : LARGE_COUNT_DEF;
    endfunction

    function automatic logic [31:0] pfirst(input int p);
        return (p == 0) ? 0 : (p == 1) ? SMALL_COUNT_DEF : SMALL_COUNT_DEF + MID_COUNT_DEF;
    endfunction

    function automatic logic [31:0] poffset(input int p);
        return (p == 0) ? 0 : (p == 1) ? SMALL_COUNT_DEF * SMALL_BYTES_DEF
                                       : SMALL_COUNT_DEF * SMALL_BYTES_DEF
                                         + MID_COUNT_DEF * MID_BYTES_DEF;
    endfunction

    // Usable address of block idx under the current base
    function automatic logic [31:0] usable_addr(input int idx);
        int p;
        p = (idx < pfirst(1)) ? 0 : (idx < pfirst(2)) ? 1 : 2;
        return area_base_q + poffset(p) + (idx - pfirst(p)) * pbytes(p) + HEADER_BYTES;
    endfunction

    // Free lists in ascending order, base back to zero
    task automatic rebuild_lists();
        area_base_q = '0;
        for (int p = 0; p < NUM_POOLS; p++) begin
            head_q[p] = 5'(pfirst(p));
            for (int k = 0; k < pcount(p); k++) begin
                link_q[pfirst(p) + k] = (k + 1 < pcount(p)) ? 5'(pfirst(p) + k + 1)
                                                            : 5'(BLK_NONE);
            end
        end
    endtask

    // Pop or push on the shadow lists and return the reply the block owes
    function automatic t_pool_reply pool_reply_for(input logic op, input logic [15:0] sz,
                                                   input logic [31:0] ad);
        t_pool_reply r;
        logic [31:0] off;
        logic [31:0] rel;
        logic [4:0]  blk;
        bit          found;
        found = 1'b0;
        if (op == OP_ALLOC) begin
            r = '{32'd0, POOL_SMALL, ST_TOO_LARGE};
            for (int p = 0; p < NUM_POOLS; p++) begin
                if (!found && {16'd0, sz} <= pbytes(p) - HEADER_BYTES) begin
                    found = 1'b1;
                    blk   = head_q[p];
                    if (blk == 5'(BLK_NONE)) begin
                        r = '{32'd0, t_pool'(p), ST_EXHAUSTED};
                    end else begin
                        head_q[p]   = link_q[blk];
                        link_q[blk] = 5'(BLK_NONE);
                        r = '{area_base_q + poffset(p) + (blk - pfirst(p)) * pbytes(p)
                              + HEADER_BYTES, t_pool'(p), ST_OK};
                    end
                end
            end
        end else begin
            r   = '{32'd0, POOL_SMALL, ST_BAD_FREE};
            off = ad - HEADER_BYTES - area_base_q;
            for (int p = 0; p < NUM_POOLS; p++) begin
                if (!found && off >= poffset(p) && off - poffset(p) < pcount(p) * pbytes(p))
                begin
                    found = 1'b1;
                    rel   = off - poffset(p);
                    if (rel % pbytes(p) == 0) begin
                        blk         = 5'(pfirst(p) + rel / pbytes(p));
                        link_q[blk] = head_q[p];
                        head_q[p]   = blk;
                        r = '{32'd0, t_pool'(p), ST_OK};
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        n_bad++;
        if (n_bad <= 10) $display("%s", msg);
    endtask

    // Result check, then record what an accepted command owes
    always @(posedge i_clk) begin : reply_chk
        t_pool_reply got;
        t_pool_reply want;
        if (i_rst_n) begin
            if (o_done) begin
                got = '{o_granted_address, o_pool_used, o_status};
                if (replies_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result addr=%h pool=%0d status=%0d",
                                            got.addr, got.pool, got.status));
                end else begin
                    want = replies_due.pop_front();
                    if (got.addr !== want.addr || got.pool !== want.pool
                        || got.status !== want.status) begin
                        flag_mismatch($sformatf(
                            {"result exp addr=%h pool=%0d status=%0d",
                             " got addr=%h pool=%0d status=%0d"},
                            want.addr, want.pool, want.status, got.addr, got.pool, got.status));
                    end
                end
            end
            if (start && !busy) begin
                want = pool_reply_for(i_opcode, i_request_size, i_block_address);
                if (i_opcode == OP_ALLOC && want.status == ST_OK) live_addrs.push_back(want.addr);
                if (typed_on) want = typed_reply;
                replies_due.push_back(want);
            end
        end
    end

    // One command transfer; returns at the falling edge after acceptance
    task automatic issue_cmd(input logic op, input logic [15:0] sz, input logic [31:0] ad,
                             input logic typed, input t_pool_reply reply);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start           <= 1'b1;
        i_opcode        <= op;
        i_request_size  <= sz;
        i_block_address <= ad;
        typed_on        <= typed;
        typed_reply     <= reply;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait until every result is in; ends on a falling edge
    task automatic drain();
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write then read-back of the base register
    task automatic set_area_base(input logic [31:0] value);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_AREA_BASE;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        area_base_q = value;
        live_addrs.delete();
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== value) flag_mismatch($sformatf("area_base read exp %h got %h", value, rd));
    endtask

    // Mostly allocations and frees of live blocks; some double frees and junk
    task automatic random_cmd(output logic op, output logic [15:0] sz, output logic [31:0] ad);
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        sz   = 16'($urandom());
        ad   = $urandom();
        if (pick < 55) begin
            op = OP_ALLOC;
            case ($urandom_range(0, 9))
                0, 1, 2: sz = 16'($urandom_range(0, 8));
                3, 4, 5: sz = 16'($urandom_range(9, 24));
                6, 7, 8: sz = 16'($urandom_range(25, 56));
                default: sz = 16'($urandom_range(0, 65535));
            endcase
        end else if (pick < 87) begin
            op = OP_FREE;
            if (live_addrs.size() != 0 && $urandom_range(0, 4) != 0) begin
                k  = $urandom_range(0, live_addrs.size() - 1);
                ad = live_addrs[k];
                live_addrs.delete(k);
            end else begin
                ad = usable_addr($urandom_range(0, BLOCKS - 1));
            end
        end else begin
            op = OP_FREE;
            case ($urandom_range(0, 2))
                0: ad = usable_addr($urandom_range(0, BLOCKS - 1)) + $urandom_range(1, 15);
                1: ad = area_base_q + REGION + HEADER_BYTES + 64 * $urandom_range(0, 3);
                default: ;
            endcase
        end
    endtask

    initial begin
        logic [31:0] bases [5];
        logic        op;
        logic [15:0] sz;
        logic [31:0] ad;

        // Directed rows: boundaries of each size class, exhaustion, bad frees
        dir_rows[0]  = '{OP_ALLOC, 16'd0,     32'hFFFF_FFFF, 1'b1, '{32'd8,   POOL_SMALL, ST_OK}};
        dir_rows[1]  = '{OP_ALLOC, 16'd8,     32'd0,         1'b0, '0};
        dir_rows[2]  = '{OP_ALLOC, 16'd9,     32'd0,         1'b1, '{32'd136, POOL_MID,   ST_OK}};
        dir_rows[3]  = '{OP_ALLOC, 16'd24,    32'd0,         1'b0, '0};
        dir_rows[4]  = '{OP_ALLOC, 16'd25,    32'd0,         1'b1, '{32'd392, POOL_LARGE, ST_OK}};
        dir_rows[5]  = '{OP_ALLOC, 16'd56,    32'd0,         1'b0, '0};
        dir_rows[6]  = '{OP_ALLOC, 16'd57,    32'd0,         1'b1,
                         '{32'd0, POOL_SMALL, ST_TOO_LARGE}};
        dir_rows[7]  = '{OP_ALLOC, 16'hFFFF,  32'd0,         1'b1,
                         '{32'd0, POOL_SMALL, ST_TOO_LARGE}};
        dir_rows[8]  = '{OP_ALLOC, 16'd56,    32'd0,         1'b0, '0};
        dir_rows[9]  = '{OP_ALLOC, 16'd56,    32'd0,         1'b0, '0};
        dir_rows[10] = '{OP_ALLOC, 16'd40,    32'd0,         1'b1,
                         '{32'd0, POOL_LARGE, ST_EXHAUSTED}};
        dir_rows[11] = '{OP_FREE,  16'hFFFF,  32'd392,       1'b1, '{32'd0, POOL_LARGE, ST_OK}};
        dir_rows[12] = '{OP_ALLOC, 16'd33,    32'd0,         1'b0, '0};
        dir_rows[13] = '{OP_FREE,  16'd0,     32'd0,         1'b1,
                         '{32'd0, POOL_SMALL, ST_BAD_FREE}};
        dir_rows[14] = '{OP_FREE,  16'd0,     32'd9,         1'b1,
                         '{32'd0, POOL_SMALL, ST_BAD_FREE}};
        dir_rows[15] = '{OP_FREE,  16'd0,     32'd648,       1'b1,
                         '{32'd0, POOL_SMALL, ST_BAD_FREE}};
        dir_rows[16] = '{OP_FREE,  16'd0,     32'hFFFF_FFFF, 1'b1,
                         '{32'd0, POOL_SMALL, ST_BAD_FREE}};
        dir_rows[17] = '{OP_FREE,  16'd0,     32'd8,         1'b0, '0};
        dir_rows[18] = '{OP_FREE,  16'd0,     32'd8,         1'b0, '0};  // double free
        dir_rows[19] = '{OP_ALLOC, 16'd1,     32'd0,         1'b0, '0};
        dir_rows[20] = '{OP_ALLOC, 16'd1,     32'd0,         1'b0, '0};
        dir_rows[21] = '{OP_FREE,  16'd0,     32'd136,       1'b0, '0};
        dir_rows[22] = '{OP_FREE,  16'd0,     32'd584,       1'b0, '0};
        dir_rows[23] = '{OP_FREE,  16'd0,     32'd128,       1'b1,
                         '{32'd0, POOL_SMALL, ST_BAD_FREE}};

        bases[0] = 32'hFFFF_FFFF;
        bases[1] = 32'hFFFF_FE80;       // region wraps through zero
        bases[2] = $urandom();
        bases[3] = 32'h0000_0000;
        bases[4] = 32'h8000_0000;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        start           = 1'b0;
        i_opcode        = OP_ALLOC;
        i_request_size  = '0;
        i_block_address = '0;
        typed_on        = 1'b0;
        typed_reply     = '0;
        n_bad           = 0;
        gaps_on         = 1'b1;
        rebuild_lists();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            issue_cmd(dir_rows[r].op, dir_rows[r].size, dir_rows[r].addr,
                      dir_rows[r].typed, dir_rows[r].reply);
        end
        drain();

        // Random phases, one per base setting
        for (int ph = 0; ph < 5; ph++) begin
            set_area_base(bases[ph]);
            for (int n = 0; n < RAND_PHASE; n++) begin
                if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
                random_cmd(op, sz, ad);
                issue_cmd(op, sz, ad, 1'b0, '0);
            end
            drain();
        end

        if (n_bad == 0) begin
            $display("segregated_block_pool_allocator_unit: match");
        end else begin
            $display("segregated_block_pool_allocator_unit: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(8 * 200000);
        $display("segregated_block_pool_allocator_unit: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/sbpa_pkg.sv
hdl/sbpa_free_map.sv
hdl/segregated_block_pool_allocator_unit.sv
verif/tb_segregated_block_pool_allocator_unit.sv
